FILE: src/segment_segment_distance_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for segment_segment_distance_core
// Concurrent check wrappers; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_DISTANCE_CORE_ASSERT_SVH
`define SEGMENT_SEGMENT_DISTANCE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SSD_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssd assertion failed");
// next-cycle implication
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssd assertion failed");
`else
`define SSD_ASSERT(label, clk, rst, ante, cons)
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: src/ssd_pkg.sv
// ---------------------------------------------------------------------------
// ssd_pkg
// Shared constants and types for the segment distance core.
// ---------------------------------------------------------------------------
package ssd_pkg;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // fraction bits of the clamped parameters s and t
  localparam int QBITS = 32;
  localparam logic [QBITS:0] ONE_Q32 = {1'b1, {QBITS{1'b0}}};

  localparam logic [31:0] SAT_VALUE = 32'hFFFF_FFFF;

  // which parameter the second divide produces
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_S,
    SEL_T
  } sel_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: src/ssd_in_if.sv
// ---------------------------------------------------------------------------
// ssd_in_if
// Input channel: one segment pair per word, signed Q16.16 coordinates.
// ---------------------------------------------------------------------------
interface ssd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_start_x;
  logic signed [31:0] first_start_y;
  logic signed [31:0] first_start_z;
  logic signed [31:0] first_end_x;
  logic signed [31:0] first_end_y;
  logic signed [31:0] first_end_z;
  logic signed [31:0] second_start_x;
  logic signed [31:0] second_start_y;
  logic signed [31:0] second_start_z;
  logic signed [31:0] second_end_x;
  logic signed [31:0] second_end_y;
  logic signed [31:0] second_end_z;

  modport source (
    output valid, first_start_x, first_start_y, first_start_z,
           first_end_x, first_end_y, first_end_z,
           second_start_x, second_start_y, second_start_z,
           second_end_x, second_end_y, second_end_z,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_start_z,
           first_end_x, first_end_y, first_end_z,
           second_start_x, second_start_y, second_start_z,
           second_end_x, second_end_y, second_end_z,
    output ready
  );
endinterface

FILE: src/ssd_out_if.sv
// ---------------------------------------------------------------------------
// ssd_out_if
// Output channel: closest distance in unsigned Q16.16 plus saturation flag.
// ---------------------------------------------------------------------------
interface ssd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] closest_distance;
  logic        saturated;

  modport source (output valid, closest_distance, saturated, input ready);
  modport sink (input valid, closest_distance, saturated, output ready);
endinterface

FILE: src/ssd_div.sv
// ---------------------------------------------------------------------------
// ssd_div
// Pipelined clamped quotient num/den as Q1.32 in [0, 1.0], one bit a stage.
// ---------------------------------------------------------------------------
module ssd_div #(
  parameter int NW  = 64,
  parameter int PLW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic signed [NW-1:0]   num,
  input  logic signed [NW-1:0]   den,
  input  logic [PLW-1:0]         in_pl,
  output logic                   out_valid,
  output logic [ssd_pkg::QBITS:0] q,
  output logic [PLW-1:0]         out_pl
);
  localparam int NS = ssd_pkg::QBITS;

  logic [NW-1:0]  rem [0:NS];
  logic [NW-1:0]  dn  [0:NS];
  logic [NS:0]    qv  [0:NS];
  logic           fix [0:NS];
  logic [PLW-1:0] pl  [0:NS];
  logic           vl  [0:NS];

  // entry: settle the clamped cases up front
  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (adv) begin
      vl[0] <= in_valid;
    end
    if (adv) begin
      rem[0] <= num;
      dn[0]  <= den;
      pl[0]  <= in_pl;
      if (num[NW-1] || (num == '0)) begin
        fix[0] <= 1'b1;
        qv[0]  <= '0;
      end else if (num >= den) begin
        fix[0] <= 1'b1;
        qv[0]  <= ssd_pkg::ONE_Q32;
      end else begin
        fix[0] <= 1'b0;
        qv[0]  <= '0;
      end
    end
  end

  for (genvar i = 1; i <= NS; i++) begin : g_stage
    logic [NW-1:0] r2;
    logic          ge;
    assign r2 = {rem[i-1][NW-2:0], 1'b0};
    assign ge = (r2 >= dn[i-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i] <= 1'b0;
      end else if (adv) begin
        vl[i] <= vl[i-1];
      end
      if (adv) begin
        rem[i] <= ge ? (r2 - dn[i-1]) : r2;
        dn[i]  <= dn[i-1];
        fix[i] <= fix[i-1];
        pl[i]  <= pl[i-1];
        qv[i]  <= fix[i-1] ? qv[i-1] : {qv[i-1][NS-1:0], ge};
      end
    end
  end

  assign out_valid = vl[NS];
  assign q         = qv[NS];
  assign out_pl    = pl[NS];
endmodule

FILE: src/ssd_isqrt.sv
// ---------------------------------------------------------------------------
// ssd_isqrt
// Pipelined floor square root of a 64-bit value, one root bit a stage.
// ---------------------------------------------------------------------------
module ssd_isqrt #(
  parameter int PLW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  logic [63:0]    y,
  input  logic [PLW-1:0] in_pl,
  output logic           out_valid,
  output logic [31:0]    root,
  output logic [PLW-1:0] out_pl
);
  localparam int NS = 32;
  localparam int RW = 35;

  logic [63:0]    ys [0:NS];
  logic [RW-1:0]  rm [0:NS];
  logic [31:0]    rt [0:NS];
  logic [PLW-1:0] pl [0:NS];
  logic           vl [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (adv) begin
      vl[0] <= in_valid;
    end
    if (adv) begin
      ys[0] <= y;
      rm[0] <= '0;
      rt[0] <= '0;
      pl[0] <= in_pl;
    end
  end

  for (genvar i = 1; i <= NS; i++) begin : g_stage
    logic [RW+1:0] rm2;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;
    logic          ge;
    assign rm2   = {rm[i-1], ys[i-1][63:62]};
    assign trial = {(RW-32)'(0), rt[i-1], 2'b01};
    assign ge    = (rm2 >= trial);
    assign diff  = rm2 - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i] <= 1'b0;
      end else if (adv) begin
        vl[i] <= vl[i-1];
      end
      if (adv) begin
        ys[i] <= {ys[i-1][61:0], 2'b00};
        rm[i] <= ge ? diff[RW-1:0] : rm2[RW-1:0];
        rt[i] <= {rt[i-1][30:0], ge};
        pl[i] <= pl[i-1];
      end
    end
  end

  assign out_valid = vl[NS];
  assign root      = rt[NS];
  assign out_pl    = pl[NS];
endmodule

FILE: src/ssd_queue.sv
// ---------------------------------------------------------------------------
// ssd_queue
// Short word queue decoupling the front from the back.
// ---------------------------------------------------------------------------
module ssd_queue #(
  parameter int W = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [W-1:0]     wr_data,
  input  logic             rd_en,
  output logic [W-1:0]     rd_data,
  output ssd_pkg::q_stat_t stat
);
  localparam int AW = ssd_pkg::QAW;

  logic [W-1:0] mem [0:ssd_pkg::QDEPTH-1];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + AW'(1);
      end
      if (rd_en) begin
        rptr <= rptr + AW'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  assign rd_data    = mem[rptr];
  assign stat.full  = (count == (AW+1)'(ssd_pkg::QDEPTH));
  assign stat.empty = (count == '0);
endmodule

FILE: src/ssd_front.sv
// ---------------------------------------------------------------------------
// ssd_front
// Takes segment pairs, forms direction vectors and the five dot products.
// ---------------------------------------------------------------------------
module ssd_front #(
  parameter int  CW  = 32,
  localparam int DW  = CW + 1,
  localparam int PW  = 2 * DW + 2,
  localparam int FPW = 9 * DW + 5 * PW
) (
  input  logic             clk,
  input  logic             rst,
  ssd_in_if.sink           seg_in,
  input  ssd_pkg::q_stat_t q_stat,
  output logic             wr_en,
  output logic [FPW-1:0]   wr_data
);
  logic adv;
  logic signed [CW-1:0] p1 [0:2];
  logic signed [CW-1:0] q1 [0:2];
  logic signed [CW-1:0] p2 [0:2];
  logic signed [CW-1:0] q2 [0:2];

  logic                 v1;
  logic signed [DW-1:0] d1 [0:2];
  logic signed [DW-1:0] d2 [0:2];
  logic signed [DW-1:0] r  [0:2];

  logic                   v2;
  logic signed [DW-1:0]   d1b [0:2];
  logic signed [DW-1:0]   d2b [0:2];
  logic signed [DW-1:0]   rb  [0:2];
  logic signed [2*DW-1:0] paa [0:2];
  logic signed [2*DW-1:0] pee [0:2];
  logic signed [2*DW-1:0] pff [0:2];
  logic signed [2*DW-1:0] pcc [0:2];
  logic signed [2*DW-1:0] pbb [0:2];

  logic signed [PW-1:0] a;
  logic signed [PW-1:0] e;
  logic signed [PW-1:0] f;
  logic signed [PW-1:0] c;
  logic signed [PW-1:0] b;

  assign adv          = !q_stat.full;
  assign seg_in.ready = adv;

  // low CW bits of each field, sign taken from bit CW-1
  assign p1[0] = CW'($unsigned(seg_in.first_start_x));
  assign p1[1] = CW'($unsigned(seg_in.first_start_y));
  assign p1[2] = CW'($unsigned(seg_in.first_start_z));
  assign q1[0] = CW'($unsigned(seg_in.first_end_x));
  assign q1[1] = CW'($unsigned(seg_in.first_end_y));
  assign q1[2] = CW'($unsigned(seg_in.first_end_z));
  assign p2[0] = CW'($unsigned(seg_in.second_start_x));
  assign p2[1] = CW'($unsigned(seg_in.second_start_y));
  assign p2[2] = CW'($unsigned(seg_in.second_start_z));
  assign q2[0] = CW'($unsigned(seg_in.second_end_x));
  assign q2[1] = CW'($unsigned(seg_in.second_end_y));
  assign q2[2] = CW'($unsigned(seg_in.second_end_z));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= seg_in.valid;
      v2 <= v1;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    always_ff @(posedge clk) begin
      if (adv) begin
        d1[k]  <= DW'(q1[k]) - DW'(p1[k]);
        d2[k]  <= DW'(q2[k]) - DW'(p2[k]);
        r[k]   <= DW'(p1[k]) - DW'(p2[k]);
        d1b[k] <= d1[k];
        d2b[k] <= d2[k];
        rb[k]  <= r[k];
        paa[k] <= d1[k] * d1[k];
        pee[k] <= d2[k] * d2[k];
        pff[k] <= d2[k] * r[k];
        pcc[k] <= d1[k] * r[k];
        pbb[k] <= d1[k] * d2[k];
      end
    end
  end

  assign a = PW'(paa[0]) + PW'(paa[1]) + PW'(paa[2]);
  assign e = PW'(pee[0]) + PW'(pee[1]) + PW'(pee[2]);
  assign f = PW'(pff[0]) + PW'(pff[1]) + PW'(pff[2]);
  assign c = PW'(pcc[0]) + PW'(pcc[1]) + PW'(pcc[2]);
  assign b = PW'(pbb[0]) + PW'(pbb[1]) + PW'(pbb[2]);

  assign wr_en   = v2 && adv;
  assign wr_data = {b, c, f, e, a, rb[2], rb[1], rb[0],
                    d2b[2], d2b[1], d2b[0], d1b[2], d1b[1], d1b[0]};
endmodule

FILE: src/ssd_back.sv
// ---------------------------------------------------------------------------
// ssd_back
// Solves for clamped s and t, forms the closest-point gap and its length.
// ---------------------------------------------------------------------------
module ssd_back #(
  parameter int  CW  = 32,
  localparam int DW  = CW + 1,
  localparam int PW  = 2 * DW + 2,
  localparam int FPW = 9 * DW + 5 * PW
) (
  input  logic             clk,
  input  logic             rst,
  input  ssd_pkg::q_stat_t q_stat,
  input  logic [FPW-1:0]   q_data,
  output logic             q_rd,
  ssd_out_if.source        dist_out
);
  localparam int NW1 = 2 * PW + 1;
  localparam int BSW = PW + 34;
  localparam int TW  = PW + 35;
  localparam int PL1 = FPW + 2;
  localparam int VW  = 9 * DW;
  localparam int PL2 = VW + 2 * (ssd_pkg::QBITS + 1) + 2;
  localparam int MW  = DW + 34;
  localparam int KW  = DW + 35;
  localparam int SQW = 2 * KW + 2;
  localparam int ZW  = (SQW > 129) ? SQW : 129;
  localparam int QB  = ssd_pkg::QBITS;

  logic adv;

  // ---- M1/B1: cross products of the dot terms, two-stage multipliers ----
  logic                   m1_v;
  logic [FPW-1:0]         m1_pl;
  logic                   m1_az;
  logic                   m1_ez;
  logic                   b1_v;
  logic signed [2*PW-1:0] b1_ae;
  logic signed [2*PW-1:0] b1_bb;
  logic signed [2*PW-1:0] b1_bf;
  logic signed [2*PW-1:0] b1_ce;
  logic [FPW-1:0]         b1_pl;
  logic                   b1_az;
  logic                   b1_ez;
  logic signed [PW-1:0]   qa, qe, qf, qc, qb;

  assign qa = q_data[VW +: PW];
  assign qe = q_data[VW + PW +: PW];
  assign qf = q_data[VW + 2*PW +: PW];
  assign qc = q_data[VW + 3*PW +: PW];
  assign qb = q_data[VW + 4*PW +: PW];

  assign adv  = !dist_out.valid || dist_out.ready;
  assign q_rd = adv && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      b1_v <= 1'b0;
    end else if (adv) begin
      m1_v <= !q_stat.empty;
      b1_v <= m1_v;
    end
    if (adv) begin
      m1_pl <= q_data;
      m1_az <= qa[PW-1] || (qa == '0);
      m1_ez <= qe[PW-1] || (qe == '0);
      b1_pl <= m1_pl;
      b1_az <= m1_az;
      b1_ez <= m1_ez;
    end
  end

  ssd_mul #(.W(PW)) u_mul_ae (.clk(clk), .adv(adv), .a(qa), .b(qe), .p(b1_ae));
  ssd_mul #(.W(PW)) u_mul_bb (.clk(clk), .adv(adv), .a(qb), .b(qb), .p(b1_bb));
  ssd_mul #(.W(PW)) u_mul_bf (.clk(clk), .adv(adv), .a(qb), .b(qf), .p(b1_bf));
  ssd_mul #(.W(PW)) u_mul_ce (.clk(clk), .adv(adv), .a(qc), .b(qe), .p(b1_ce));

  // ---- first divide: unclamped-t solution for s ----
  logic signed [NW1-1:0] denom, snum, num1, den1;
  logic                  dpos;

  assign denom = NW1'(b1_ae) - NW1'(b1_bb);
  assign snum  = NW1'(b1_bf) - NW1'(b1_ce);
  assign dpos  = !denom[NW1-1] && (denom != '0);
  assign num1  = (!b1_az && !b1_ez && dpos) ? snum : NW1'(0);
  assign den1  = dpos ? denom : NW1'(1);

  logic           dv1_v;
  logic [QB:0]    s0;
  logic [PL1-1:0] dv1_pl;

  ssd_div #(.NW(NW1), .PLW(PL1)) u_div_s (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (b1_v),
    .num      (num1),
    .den      (den1),
    .in_pl    ({b1_az, b1_ez, b1_pl}),
    .out_valid(dv1_v),
    .q        (s0),
    .out_pl   (dv1_pl)
  );

  // ---- T0/T1: b * s, two-stage multiplier ----
  logic                   t0_v;
  logic [QB:0]            t0_s0;
  logic [PL1-1:0]         t0_pl;
  logic                   t1_v;
  logic signed [2*PW-1:0] t1_p;
  logic signed [BSW-1:0]  t1_bs;
  logic [QB:0]            t1_s0;
  logic [PL1-1:0]         t1_pl;
  logic signed [PW-1:0]   s0b;
  logic signed [PW-1:0]   s0w;

  assign s0b   = dv1_pl[VW + 4*PW +: PW];
  assign s0w   = {(PW-QB-1)'(0), s0};
  assign t1_bs = t1_p[BSW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_v <= 1'b0;
      t1_v <= 1'b0;
    end else if (adv) begin
      t0_v <= dv1_v;
      t1_v <= t0_v;
    end
    if (adv) begin
      t0_s0 <= s0;
      t0_pl <= dv1_pl;
      t1_s0 <= t0_s0;
      t1_pl <= t0_pl;
    end
  end

  ssd_mul #(.W(PW)) u_mul_bs (.clk(clk), .adv(adv), .a(s0b), .b(s0w), .p(t1_p));

  // ---- case selection feeding the second divide ----
  logic signed [PW-1:0] ta, te, tf, tc, tb;
  logic                 taz, tez;
  logic signed [TW-1:0] tnum, tden, num2, den2;
  logic [QB:0]          s_keep, t_keep;
  ssd_pkg::sel_t        sel;

  assign ta  = t1_pl[VW +: PW];
  assign te  = t1_pl[VW + PW +: PW];
  assign tf  = t1_pl[VW + 2*PW +: PW];
  assign tc  = t1_pl[VW + 3*PW +: PW];
  assign tb  = t1_pl[VW + 4*PW +: PW];
  assign taz = t1_pl[FPW + 1];
  assign tez = t1_pl[FPW];

  assign tnum = TW'(t1_bs) + (TW'(tf) <<< QB);
  assign tden = TW'(te) <<< QB;

  always_comb begin
    sel    = ssd_pkg::SEL_NONE;
    s_keep = '0;
    t_keep = '0;
    num2   = TW'(0);
    den2   = TW'(1);
    if (taz && tez) begin
      sel = ssd_pkg::SEL_NONE;
    end else if (taz) begin
      sel  = ssd_pkg::SEL_T;
      num2 = TW'(tf);
      den2 = TW'(te);
    end else if (tez) begin
      sel  = ssd_pkg::SEL_S;
      num2 = TW'(0) - TW'(tc);
      den2 = TW'(ta);
    end else if (tnum[TW-1]) begin
      // t clamps low, s re-solved against t = 0
      sel  = ssd_pkg::SEL_S;
      num2 = TW'(0) - TW'(tc);
      den2 = TW'(ta);
    end else if (tnum > tden) begin
      // t clamps high, s re-solved against t = 1
      sel    = ssd_pkg::SEL_S;
      t_keep = ssd_pkg::ONE_Q32;
      num2   = TW'(tb) - TW'(tc);
      den2   = TW'(ta);
    end else begin
      sel    = ssd_pkg::SEL_T;
      s_keep = t1_s0;
      num2   = tnum;
      den2   = tden;
    end
  end

  logic           dv2_v;
  logic [QB:0]    q2;
  logic [PL2-1:0] dv2_pl;

  ssd_div #(.NW(TW), .PLW(PL2)) u_div_st (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (t1_v),
    .num      (num2),
    .den      (den2),
    .in_pl    ({sel, s_keep, t_keep, t1_pl[VW-1:0]}),
    .out_valid(dv2_v),
    .q        (q2),
    .out_pl   (dv2_pl)
  );

  ssd_pkg::sel_t o_sel;
  logic [QB:0]   fs, ft;

  assign o_sel = ssd_pkg::sel_t'(dv2_pl[PL2-1 -: 2]);
  assign fs    = (o_sel == ssd_pkg::SEL_S) ? q2 : dv2_pl[VW + QB + 1 +: QB + 1];
  assign ft    = (o_sel == ssd_pkg::SEL_T) ? q2 : dv2_pl[VW +: QB + 1];

  // ---- D1..D5: gap vector, squares (two stages), sum ----
  logic                 d1_v, d2_v, d3_v, d4_v, d5_v;
  logic signed [MW-1:0] ds [0:2];
  logic signed [MW-1:0] dt [0:2];
  logic signed [DW-1:0] dr [0:2];
  logic signed [KW-1:0] dk [0:2];
  logic signed [2*KW-1:0] sq [0:2];
  logic signed [ZW-1:0] sumz;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v <= 1'b0;
      d2_v <= 1'b0;
      d3_v <= 1'b0;
      d4_v <= 1'b0;
      d5_v <= 1'b0;
    end else if (adv) begin
      d1_v <= dv2_v;
      d2_v <= d1_v;
      d3_v <= d2_v;
      d4_v <= d3_v;
      d5_v <= d4_v;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_gap
    logic signed [DW-1:0] u1, u2;
    assign u1 = dv2_pl[k*DW +: DW];
    assign u2 = dv2_pl[(3+k)*DW +: DW];
    always_ff @(posedge clk) begin
      if (adv) begin
        ds[k] <= u1 * $signed({1'b0, fs});
        dt[k] <= u2 * $signed({1'b0, ft});
        dr[k] <= dv2_pl[(6+k)*DW +: DW];
        dk[k] <= (KW'(dr[k]) <<< QB) + KW'(ds[k]) - KW'(dt[k]);
      end
    end
    ssd_mul #(.W(KW)) u_mul_sq (.clk(clk), .adv(adv), .a(dk[k]), .b(dk[k]), .p(sq[k]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sumz <= ZW'(sq[0]) + ZW'(sq[1]) + ZW'(sq[2]);
    end
  end

  // ---- square root and output word ----
  logic        over;
  logic        sq_v;
  logic [31:0] root;
  logic        sq_over;

  assign over = |sumz[ZW-1:128];

  ssd_isqrt #(.PLW(1)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (d5_v),
    .y        (sumz[127:64]),
    .in_pl    (over),
    .out_valid(sq_v),
    .root     (root),
    .out_pl   (sq_over)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_out.valid <= 1'b0;
    end else if (adv) begin
      dist_out.valid <= sq_v;
    end
    if (adv) begin
      dist_out.closest_distance <= sq_over ? ssd_pkg::SAT_VALUE : root;
      dist_out.saturated        <= sq_over;
    end
  end
endmodule

// signed W x W multiply over two stages: half-width partial products, then sum
module ssd_mul #(
  parameter int W = 68
) (
  input  logic                  clk,
  input  logic                  adv,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);
  localparam int H  = W / 2;
  localparam int U  = W - H;
  localparam int P2 = 2 * W;

  logic signed [U-1:0]   ah, bh;
  logic [H-1:0]          al, bl;
  logic signed [2*U-1:0] pp_hh;
  logic signed [U+H:0]   pp_hl;
  logic signed [U+H:0]   pp_lh;
  logic [2*H-1:0]        pp_ll;

  assign ah = a[W-1:H];
  assign bh = b[W-1:H];
  assign al = a[H-1:0];
  assign bl = b[H-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      pp_hh <= ah * bh;
      pp_hl <= ah * $signed({1'b0, bl});
      pp_lh <= $signed({1'b0, al}) * bh;
      pp_ll <= al * bl;
      p     <= (P2'(pp_hh) << (2 * H)) + (P2'(pp_hl) << H) + (P2'(pp_lh) << H)
               + P2'(pp_ll);
    end
  end
endmodule

FILE: src/segment_segment_distance_core.sv
// ---------------------------------------------------------------------------
// segment_segment_distance_core
// Closest-approach distance between two 3D segments, Q16.16 in and out.
// ---------------------------------------------------------------------------
// Takes one segment pair per word and returns one distance word per pair, in
// order. Throughput is one pair per clock when the output side keeps up.
// The pipeline depth comes mostly from the two 33-stage restoring dividers
// (one quotient bit a stage) and the 33-stage square root (one root bit a
// stage); the wide products in the back are split into half-width partial
// products over two stages each. The front (direction vectors and dot
// products, two stages) writes into a four-word queue; the back pulls from
// it and stalls as a unit only while its output word is held. Inputs use the
// low COORD_WIDTH bits of each field as signed Q16.16. A distance beyond the
// 32-bit output range returns all ones with saturated set.
// ---------------------------------------------------------------------------
`include "segment_segment_distance_core_assert.svh"

module segment_segment_distance_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  ssd_in_if.sink    seg_in,
  ssd_out_if.source dist_out
);
  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW + 2;
  localparam int FPW = 9 * DW + 5 * PW;

  // queue handshake between front and back
  logic             q_wr;
  logic             q_rd;
  logic [FPW-1:0]   q_wdata;
  logic [FPW-1:0]   q_rdata;
  ssd_pkg::q_stat_t q_stat;
  logic             sat_word;

  // front: deltas and dot products a, b, c, e, f
  ssd_front #(.CW(COORD_WIDTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .seg_in (seg_in),
    .q_stat (q_stat),
    .wr_en  (q_wr),
    .wr_data(q_wdata)
  );

  ssd_queue #(.W(FPW)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr),
    .wr_data(q_wdata),
    .rd_en  (q_rd),
    .rd_data(q_rdata),
    .stat   (q_stat)
  );

  // back: case split, clamped s/t, gap length
  ssd_back #(.CW(COORD_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .q_data  (q_rdata),
    .q_rd    (q_rd),
    .dist_out(dist_out)
  );

  assign sat_word = dist_out.valid && dist_out.saturated;

  // front only pushes when the queue has room
  `SSD_ASSERT(a_q_no_overflow, clk, rst, q_wr, !q_stat.full)
  // back only pops a filled queue
  `SSD_ASSERT(a_q_no_underflow, clk, rst, q_rd, !q_stat.empty)
  // a saturated word always carries the ceiling value
  `SSD_ASSERT(a_sat_ceiling, clk, rst, sat_word, dist_out.closest_distance == ssd_pkg::SAT_VALUE)

endmodule

FILE: dv/tb_segment_segment_distance_core.sv
// ---------------------------------------------------------------------------
// tb_segment_segment_distance_core
// Self-checking bench for the segment-to-segment closest distance core.
// ---------------------------------------------------------------------------
// A short table of hand-picked segment pairs (points, parallel, crossing,
// extremes) is followed by random pairs of several shapes. Each accepted pair
// is checked against a hand-given value or an exact wide-integer model of the
// clamped closest-point method; results come back in order and are compared
// field by field. The sender runs in bursts, the receiver stalls on its own
// pattern and once holds off long enough to back the core up into its input.
// ---------------------------------------------------------------------------
module tb_segment_segment_distance_core;

  localparam int ONE        = 65536;   // 1.0 in Q16.16
  localparam int N_RANDOM   = 600;
  localparam int IDLE_LIMIT = 4000;    // cycles with no word moving
  localparam int DRAIN_WAIT = 150;     // extra wait after the last expected result
  localparam int HOLD_LEN   = 400;     // long receiver hold-off

  // all coordinate sums and products fit well inside 256 bits
  typedef logic signed [255:0] wide_t;
  // twelve fields: first start xyz, first end xyz, second start xyz, second end xyz
  typedef logic [11:0][31:0] pair_t;

  typedef struct {
    pair_t       pair;
    bit          typed;     // expected value given by hand
    logic [31:0] distance;
    logic        sat;
  } dir_row_t;

  typedef struct {
    logic [31:0] distance;
    logic        sat;
  } dist_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ssd_in_if  seg_in ();
  ssd_out_if dist_out ();

  segment_segment_distance_core uut (
    .clk      (clk),
    .rst      (rst),
    .seg_in   (seg_in),
    .dist_out (dist_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dist_word_t pending_dist_q[$];
  int         n_errors    = 0;
  int         n_sent      = 0;
  int         n_received  = 0;
  int         n_saturated = 0;
  int         idle_cycles = 0;

  // -------------------------------------------------------------------------
  // Predictor: exact integer version of the clamped closest-point search.
  // -------------------------------------------------------------------------
  function automatic wide_t widen(logic [31:0] v);
    logic signed [31:0] sv;
    sv = v;
    return wide_t'(sv);
  endfunction

  function automatic wide_t dot3(wide_t u[3], wide_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  // num/den clamped to [0,1] as Q1.32, truncated; den > 0
  function automatic wide_t clamp_quot(wide_t num, wide_t den);
    if (num <= 0) return 0;
    if (num >= den) return wide_t'(1) <<< 32;
    return (num <<< 32) / den;
  endfunction

  function automatic logic [31:0] root64(logic [63:0] y);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > y) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (y >= res + bitv) begin
        y   = y - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic dist_word_t predict_distance(pair_t p);
    wide_t      d1[3], d2[3], r[3];
    wide_t      a, e, f, c, b, denom, tnum, tden, s, t, sum, dk;
    dist_word_t w;
    for (int k = 0; k < 3; k++) begin
      d1[k] = widen(p[3 + k]) - widen(p[k]);
      d2[k] = widen(p[9 + k]) - widen(p[6 + k]);
      r[k]  = widen(p[k]) - widen(p[6 + k]);
    end
    a = dot3(d1, d1);
    e = dot3(d2, d2);
    f = dot3(d2, r);
    c = dot3(d1, r);
    s = 0;
    t = 0;
    if (a <= 0 && e <= 0) begin
      // both degenerate: the two points themselves
    end else if (a <= 0) begin
      t = clamp_quot(f, e);
    end else if (e <= 0) begin
      s = clamp_quot(-c, a);
    end else begin
      b     = dot3(d1, d2);
      denom = a * e - b * b;
      if (denom > 0) s = clamp_quot(b * f - c * e, denom);
      tnum = b * s + (f <<< 32);
      tden = e <<< 32;
      if (tnum < 0) begin
        t = 0;
        s = clamp_quot(-c, a);
      end else if (tnum > tden) begin
        t = wide_t'(1) <<< 32;
        s = clamp_quot(b - c, a);
      end else begin
        t = clamp_quot(tnum, tden);
      end
    end
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      dk  = (r[k] <<< 32) + d1[k] * s - d2[k] * t;
      sum = sum + dk * dk;
    end
    if (|sum[255:128]) begin
      w.distance = ssd_pkg::SAT_VALUE;
      w.sat      = 1'b1;
    end else begin
      w.distance = root64(sum[127:64]);
      w.sat      = 1'b0;
    end
    return w;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus building
  // -------------------------------------------------------------------------
  function automatic pair_t mk_pair(int fsx, int fsy, int fsz, int fex, int fey, int fez,
                                    int ssx, int ssy, int ssz, int sex, int sey, int sez);
    pair_t p;
    p = {sez, sey, sex, ssz, ssy, ssx, fez, fey, fex, fsz, fsy, fsx};
    return p;
  endfunction

  function automatic int near_coord();
    return int'($urandom_range(0, 1 << 21)) - (1 << 20);   // about +/-16.0
  endfunction

  function automatic pair_t random_pair();
    pair_t       p;
    int unsigned shape;
    int          kscale;
    shape = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++) p[k] = near_coord();
    case (shape)
      0, 1: begin
        for (int k = 0; k < 12; k++) p[k] = $urandom;     // full range, often saturates
      end
      2: begin
        for (int k = 0; k < 3; k++) p[3 + k] = p[k];      // first segment is a point
      end
      3: begin
        for (int k = 0; k < 3; k++) p[9 + k] = p[6 + k];  // second segment is a point
      end
      4: begin
        for (int k = 0; k < 3; k++) begin                 // both points
          p[3 + k] = p[k];
          p[9 + k] = p[6 + k];
        end
      end
      5: begin
        kscale = int'($urandom_range(0, 6)) - 3;          // parallel or antiparallel
        if (kscale == 0) kscale = 2;
        for (int k = 0; k < 3; k++)
          p[9 + k] = p[6 + k] + kscale * (int'(p[3 + k]) - int'(p[k])) / 2;
      end
      6: begin
        for (int k = 0; k < 12; k++)                      // large, near the edge of range
          p[k] = int'($urandom_range(0, 1 << 30)) - (1 << 29) + (k[0] ? (1 << 30) : 0);
      end
      default: begin
        // general case with random small coordinates
      end
    endcase
    return p;
  endfunction

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("[%0t] MISMATCH %s: got 0x%08h expected 0x%08h", $time, what, got, want);
  endtask

  // output side: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    dist_word_t want;
    if (!rst && dist_out.valid && dist_out.ready) begin
      n_received++;
      if (pending_dist_q.size() == 0) begin
        report_mismatch("unexpected word", dist_out.closest_distance, 32'h0);
      end else begin
        want = pending_dist_q.pop_front();
        if (dist_out.closest_distance !== want.distance)
          report_mismatch("closest_distance", dist_out.closest_distance, want.distance);
        if (dist_out.saturated !== want.sat)
          report_mismatch("saturated", {31'h0, dist_out.saturated}, {31'h0, want.sat});
        if (want.sat) n_saturated++;
      end
    end
  end

  // watchdog: any word moving on either side resets the count
  always @(posedge clk) begin
    if (rst || (seg_in.valid && seg_in.ready) || (dist_out.valid && dist_out.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: stall pattern redrawn from four ready percentages; one long hold-off
  // while the sender keeps pushing, to fill the internal queue.
  // -------------------------------------------------------------------------
  initial begin
    int unsigned pct;
    int          cyc;
    bit          held;
    dist_out.ready = 1'b0;
    cyc  = 0;
    held = 1'b0;
    pct  = 100;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && n_received >= 120) begin
        held = 1'b1;
        dist_out.ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 3))
          0:       pct = 100;
          1:       pct = 75;
          2:       pct = 40;
          default: pct = 10;
        endcase
      end
      dist_out.ready <= ($urandom_range(1, 100) <= pct);
      cyc++;
      @(negedge clk);
    end
  end

  // -------------------------------------------------------------------------
  // Sender: directed table, then random pairs, in bursts with gaps.
  // -------------------------------------------------------------------------
  task automatic send_pair(pair_t p, bit typed, logic [31:0] tdist, logic tsat);
    dist_word_t w;
    seg_in.valid          <= 1'b1;
    seg_in.first_start_x  <= p[0];
    seg_in.first_start_y  <= p[1];
    seg_in.first_start_z  <= p[2];
    seg_in.first_end_x    <= p[3];
    seg_in.first_end_y    <= p[4];
    seg_in.first_end_z    <= p[5];
    seg_in.second_start_x <= p[6];
    seg_in.second_start_y <= p[7];
    seg_in.second_start_z <= p[8];
    seg_in.second_end_x   <= p[9];
    seg_in.second_end_y   <= p[10];
    seg_in.second_end_z   <= p[11];
    do @(posedge clk); while (!seg_in.ready);
    if (typed) begin
      w.distance = tdist;
      w.sat      = tsat;
    end else begin
      w = predict_distance(p);
    end
    pending_dist_q.push_back(w);
    n_sent++;
    @(negedge clk);
  endtask

  dir_row_t dir_table[$];

  initial begin
    int burst;
    int gap;
    seg_in.valid = 1'b0;
    {seg_in.first_start_x, seg_in.first_start_y, seg_in.first_start_z} = '0;
    {seg_in.first_end_x, seg_in.first_end_y, seg_in.first_end_z} = '0;
    {seg_in.second_start_x, seg_in.second_start_y, seg_in.second_start_z} = '0;
    {seg_in.second_end_x, seg_in.second_end_y, seg_in.second_end_z} = '0;

    // all coordinates zero
    dir_table.push_back('{mk_pair(0,0,0, 0,0,0, 0,0,0, 0,0,0), 1, 32'h0, 1'b0});
    // two points, 3-4-5 triangle
    dir_table.push_back('{mk_pair(0,0,0, 0,0,0, 3*ONE,4*ONE,0, 3*ONE,4*ONE,0),
                          1, 5*ONE, 1'b0});
    // first is a point above the middle of the second
    dir_table.push_back('{mk_pair(0,5*ONE,0, 0,5*ONE,0, -2*ONE,0,0, 2*ONE,0,0),
                          1, 5*ONE, 1'b0});
    // second is a point above the middle of the first
    dir_table.push_back('{mk_pair(-2*ONE,0,0, 2*ONE,0,0, 0,0,7*ONE, 0,0,7*ONE),
                          1, 7*ONE, 1'b0});
    // crossing at right angles, offset in z: s = t = 1/2
    dir_table.push_back('{mk_pair(-ONE,0,0, ONE,0,0, 0,-ONE,2*ONE, 0,ONE,2*ONE),
                          1, 2*ONE, 1'b0});
    // far corners, both points: beyond the output range
    dir_table.push_back('{mk_pair(32'h8000_0000,32'h8000_0000,32'h8000_0000,
                                  32'h8000_0000,32'h8000_0000,32'h8000_0000,
                                  32'h7FFF_FFFF,32'h7FFF_FFFF,32'h7FFF_FFFF,
                                  32'h7FFF_FFFF,32'h7FFF_FFFF,32'h7FFF_FFFF),
                          1, ssd_pkg::SAT_VALUE, 1'b1});
    // parallel, side by side
    dir_table.push_back('{mk_pair(0,0,0, 4*ONE,0,0, ONE,3*ONE,0, 5*ONE,3*ONE,0),
                          0, 0, 0});
    // antiparallel, overlapping
    dir_table.push_back('{mk_pair(0,0,0, 4*ONE,0,0, 5*ONE,ONE,0, ONE,ONE,0), 0, 0, 0});
    // collinear, disjoint
    dir_table.push_back('{mk_pair(0,0,0, ONE,0,0, 3*ONE,0,0, 5*ONE,0,0), 0, 0, 0});
    // skew, t clamped at the start of the second
    dir_table.push_back('{mk_pair(0,0,0, ONE,0,0, 3*ONE,ONE,ONE, 3*ONE,5*ONE,2*ONE),
                          0, 0, 0});
    // skew, t clamped at the end of the second
    dir_table.push_back('{mk_pair(0,0,0, ONE,0,0, 3*ONE,-5*ONE,ONE, 3*ONE,-ONE,2*ONE),
                          0, 0, 0});
    // general case with odd fractions
    dir_table.push_back('{mk_pair(1,-1,3, 7*ONE+5,-2*ONE,ONE-1, -3*ONE,ONE/3,2,
                                  ONE,-ONE/7,5*ONE), 0, 0, 0});
    // full-range diagonals through each other
    dir_table.push_back('{mk_pair(32'h8000_0000,32'h8000_0000,32'h8000_0000,
                                  32'h7FFF_FFFF,32'h7FFF_FFFF,32'h7FFF_FFFF,
                                  32'h7FFF_FFFF,32'h8000_0000,32'h7FFF_FFFF,
                                  32'h8000_0000,32'h7FFF_FFFF,32'h8000_0000),
                          0, 0, 0});
    // full-range parallel, far apart
    dir_table.push_back('{mk_pair(32'h8000_0000,0,0, 32'h7FFF_FFFF,0,0,
                                  32'h8000_0000,32'h7FFF_FFFF,0,
                                  32'h7FFF_FFFF,32'h7FFF_FFFF,0), 0, 0, 0});
    // single LSB apart
    dir_table.push_back('{mk_pair(0,0,0, 0,0,1, 1,0,0, 1,0,1), 0, 0, 0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_table[i])
      send_pair(dir_table[i].pair, dir_table[i].typed, dir_table[i].distance,
                dir_table[i].sat);

    burst = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
          seg_in.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 40);
      end
      burst--;
      send_pair(random_pair(), 0, 0, 0);
    end
    seg_in.valid <= 1'b0;

    wait (pending_dist_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run covered %0d segment pairs (%0d directed), %0d results, %0d saturated",
             n_sent, dir_table.size(), n_received, n_saturated);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
